FILE: design/spg_pkg.sv
package spg_pkg;

  // Default table depth.
  localparam int unsigned MaxPointsDefault = 128;

  // The triangle is built from four quadrants of the period.
  localparam int unsigned Quadrants = 4;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_MANUAL = 2'd2,
    CMD_START  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_KIND   = 3'd0,
    REG_LENGTH = 3'd1,
    REG_PERIOD = 3'd2,
    REG_AMP    = 3'd3,
    REG_OFFSET = 3'd4
  } reg_e;

  typedef struct packed {
    logic signed [31:0] location;
    logic        [31:0] dwell;
  } table_entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

FILE: design/spg_if.sv
interface spg_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [31:0]        timestamp;
  logic [6:0]         entry_index;
  logic signed [31:0] position_value;
  logic [31:0]        dwell_ticks;

  modport source (output valid, command, timestamp, entry_index, position_value,
                  dwell_ticks, input ready);
  modport sink (input valid, command, timestamp, entry_index, position_value,
                dwell_ticks, output ready);
endinterface

interface spg_sp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] setpoint;
  logic [6:0]         point_index;
  logic               cycle_restart;
  logic               manual_mode;

  modport source (output valid, setpoint, point_index, cycle_restart, manual_mode,
                  input ready);
  modport sink (input valid, setpoint, point_index, cycle_restart, manual_mode,
                output ready);
endinterface

FILE: design/scan_profile_setpoint_generator.sv
// Channel    Dir  Payload                                               Accepted when
// cmd_if     in   command, timestamp, entry_index, position_value,      valid & ready
//                 dwell_ticks
// sp_if      out  setpoint, point_index, cycle_restart, manual_mode     valid & ready
// cfg        in   cfg_we_i, cfg_index_i, cfg_data_i                     cfg_we_i
//
// Load, manual and start requests are handled in the idle state. A manual tick passes
// straight to the output register; a table tick first waits in S_TBL for the synchronous
// table read. A triangle tick takes the request, runs the quadrant search by repeated
// subtraction, the multiply and the bit-serial divider, and then passes the result to the
// output register.
// Reset is asynchronous and active low; the tables are not cleared.
// A finished result waits in the output register while the next request is taken.
module scan_profile_setpoint_generator #(
  parameter int unsigned MAX_POINTS = spg_pkg::MaxPointsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spg_cmd_if.sink    cmd_if,
  spg_sp_if.source   sp_if,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import spg_pkg::*;

  localparam int unsigned Aw = $clog2(MAX_POINTS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TBL  = 6'b000010,
    S_QUAD = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic        kind_q;
  logic [7:0]  length_q;
  logic [31:0] period_q;
  logic [31:0] amp_q;
  logic [31:0] off_q;

  // Profile state.
  logic [Aw-1:0] pos_q, pos_d;
  logic [31:0]   last_q, last_d;
  logic [31:0]   cstart_q, cstart_d;
  logic [31:0]   held_q, held_d;
  logic          running_q, running_d;

  // Working registers for the request in progress.
  logic [31:0] ts_q, ts_d;
  logic [33:0] u_q, u_d;
  logic [2:0]  k_q, k_d;

  // Result being assembled and the output register.
  logic signed [31:0] res_sp_q, res_sp_d;
  logic [6:0]         res_pt_q, res_pt_d;
  logic               res_rs_q, res_rs_d;
  logic               res_man_q, res_man_d;
  logic               ov_q, ov_d;
  logic signed [31:0] o_sp_q;
  logic [6:0]         o_pt_q;
  logic               o_rs_q, o_man_q;

  logic         accept;
  logic         mem_we, mem_re;
  table_entry_t mem_wdata, mem_rdata;
  logic [Aw-1:0] mem_waddr;
  div_req_t     div_req;
  div_rsp_t     div_rsp;

  logic [31:0]        t_raw, len, len_m1, mag_a;
  logic               amp_neg;
  logic signed [33:0] a_ext, ramp, vq;
  logic signed [34:0] sum;
  logic               out_free;

  spg_table_mem #(.Depth(MAX_POINTS), .Aw(Aw)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (pos_q),
    .rdata_o (mem_rdata)
  );

  spg_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cmd_if.ready = state_q == S_IDLE;
  assign accept       = cmd_if.valid && cmd_if.ready;
  assign out_free     = !ov_q || sp_if.ready;

  // Table writes happen only on a load request whose index lies inside the table.
  assign mem_we          = accept && cmd_if.command == CMD_LOAD
                           && 32'(cmd_if.entry_index) < MAX_POINTS;
  assign mem_waddr       = Aw'(cmd_if.entry_index);
  assign mem_wdata.location = cmd_if.position_value;
  assign mem_wdata.dwell    = cmd_if.dwell_ticks;
  assign mem_re          = accept && cmd_if.command == CMD_TICK && running_q && !kind_q;

  // The amplitude magnitude; the most negative value maps to 2^31, which still fits.
  assign amp_neg = amp_q[31];
  assign mag_a   = amp_neg ? 32'(-amp_q) : amp_q;
  assign a_ext   = {{2{amp_q[31]}}, amp_q};

  assign div_req.start    = state_q == S_MUL;
  assign div_req.dividend = mag_a * u_q[31:0];
  assign div_req.divisor  = period_q;

  // Playback length clamped to one point at least and the table depth at most.
  always_comb begin
    len = {24'd0, length_q};
    if (len == 32'd0) begin
      len = 32'd1;
    end else if (len > MAX_POINTS) begin
      len = MAX_POINTS;
    end
    len_m1 = len - 32'd1;
  end

  assign t_raw = cmd_if.timestamp - cstart_q;

  // Ramp sign follows the amplitude; quadrant selection and the offset sum follow; saturation is applied in S_DIV.
  always_comb begin
    ramp = period_q == 32'd0 ? 34'sd0 : $signed({2'b00, div_rsp.quotient});
    if (amp_neg) begin
      ramp = -ramp;
    end
    case (k_q)
      3'd0:    vq = ramp;
      3'd1:    vq = a_ext - ramp;
      3'd2:    vq = -ramp;
      3'd3:    vq = ramp - a_ext;
      default: vq = 34'sd0;
    endcase
    sum = {vq[33], vq} + {{3{off_q[31]}}, off_q};
  end

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    last_d    = last_q;
    cstart_d  = cstart_q;
    held_d    = held_q;
    running_d = running_q;
    ts_d      = ts_q;
    u_d       = u_q;
    k_d       = k_q;
    res_sp_d  = res_sp_q;
    res_pt_d  = res_pt_q;
    res_rs_d  = res_rs_q;
    res_man_d = res_man_q;
    ov_d      = ov_q && !sp_if.ready;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_if.command)
            CMD_MANUAL: begin
              held_d    = cmd_if.position_value;
              running_d = 1'b0;
            end
            CMD_START: begin
              running_d = 1'b1;
              pos_d     = '0;
              last_d    = cmd_if.timestamp;
              cstart_d  = cmd_if.timestamp;
            end
            CMD_TICK: begin
              ts_d      = cmd_if.timestamp;
              res_pt_d  = '0;
              res_rs_d  = 1'b0;
              res_man_d = 1'b0;
              if (!running_q) begin
                res_sp_d  = held_q;
                res_man_d = 1'b1;
                state_d   = S_OUT;
              end else if (!kind_q) begin
                state_d = S_TBL;
              end else begin
                u_d = {t_raw, 2'b00};
                if (t_raw > period_q) begin
                  cstart_d = cmd_if.timestamp;
                  u_d      = '0;
                  res_rs_d = 1'b1;
                end
                k_d     = '0;
                state_d = S_QUAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_TBL: begin
        res_sp_d = mem_rdata.location;
        if (ts_q - last_q >= mem_rdata.dwell) begin
          last_d = ts_q;
          if (32'(pos_q) >= len_m1) begin
            pos_d    = '0;
            cstart_d = ts_q;
            res_rs_d = 1'b1;
          end else begin
            pos_d = pos_q + Aw'(1);
          end
        end
        res_pt_d = 7'(pos_d);
        state_d  = S_OUT;
      end
      S_QUAD: begin
        // Find the quadrant by repeated subtraction; t never exceeds the period.
        if (period_q != 32'd0 && u_q >= {2'b00, period_q}
            && 32'(k_q) < Quadrants) begin
          u_d = u_q - {2'b00, period_q};
          k_d = k_q + 3'd1;
        end else begin
          if (period_q == 32'd0) begin
            u_d = '0;
          end
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (sum > 35'sd2147483647) begin
            res_sp_d = 32'sh7fffffff;
          end else if (sum < -35'sd2147483648) begin
            res_sp_d = 32'sh80000000;
          end else begin
            res_sp_d = sum[31:0];
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      kind_q    <= 1'b0;
      length_q  <= 8'd1;
      period_q  <= 32'd1000000;
      amp_q     <= 32'd32768;
      off_q     <= 32'd0;
      pos_q     <= '0;
      last_q    <= '0;
      cstart_q  <= '0;
      held_q    <= '0;
      running_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      last_q    <= last_d;
      cstart_q  <= cstart_d;
      held_q    <= held_d;
      running_q <= running_d;
      ov_q      <= ov_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_KIND:   kind_q   <= cfg_data_i[0];
          REG_LENGTH: length_q <= cfg_data_i[7:0];
          REG_PERIOD: period_q <= cfg_data_i;
          REG_AMP:    amp_q    <= cfg_data_i;
          REG_OFFSET: off_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ts_q      <= ts_d;
    u_q       <= u_d;
    k_q       <= k_d;
    res_sp_q  <= res_sp_d;
    res_pt_q  <= res_pt_d;
    res_rs_q  <= res_rs_d;
    res_man_q <= res_man_d;
    if (state_q == S_OUT && out_free) begin
      o_sp_q  <= res_sp_q;
      o_pt_q  <= res_pt_q;
      o_rs_q  <= res_rs_q;
      o_man_q <= res_man_q;
    end
  end

  assign sp_if.valid         = ov_q;
  assign sp_if.setpoint      = o_sp_q;
  assign sp_if.point_index   = o_pt_q;
  assign sp_if.cycle_restart = o_rs_q;
  assign sp_if.manual_mode   = o_man_q;

  as_tick_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_if.command == CMD_TICK) |=> state_q != S_IDLE)
    else $error("tick request produced no work");
  as_other_stays_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_if.command != CMD_TICK) |=> state_q == S_IDLE)
    else $error("non-tick request started work");
  as_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV) else $error("divider result unexpected");
  as_pos_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < MAX_POINTS) else $error("table position out of range");

endmodule

FILE: design/spg_table_mem.sv
module spg_table_mem #(
  parameter int unsigned Depth = 128,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [Aw-1:0]         waddr_i,
  input  spg_pkg::table_entry_t wdata_i,
  input  logic                  re_i,
  input  logic [Aw-1:0]         raddr_i,
  output spg_pkg::table_entry_t rdata_o
);
  import spg_pkg::*;

  // Location and dwell of each point share one word.
  table_entry_t mem [Depth];
  table_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/spg_divider.sv
module spg_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spg_pkg::div_req_t   req_i,
  output spg_pkg::div_rsp_t   rsp_o
);
  import spg_pkg::*;

  // Restoring division, one quotient bit per cycle. The caller guarantees that
  // the upper half of the dividend is below the divisor.
  logic [31:0] rem_q, rem_d;
  logic [31:0] low_q, low_d;
  logic [31:0] div_q, div_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [32:0] trial;
  logic        fits;

  always_comb begin
    trial  = {rem_q, low_q[31]};
    fits   = trial >= {1'b0, div_q};
    rem_d  = rem_q;
    low_d  = low_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = req_i.dividend[63:32];
      low_d = req_i.dividend[31:0];
      div_d = req_i.divisor;
      cnt_d = 6'd32;
    end else if (cnt_q != 6'd0) begin
      rem_d  = fits ? 32'(trial - {1'b0, div_q}) : trial[31:0];
      low_d  = {low_q[30:0], fits};
      cnt_d  = cnt_q - 6'd1;
      done_d = cnt_q == 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = low_q;

  as_done_after_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cnt_q) == 6'd1) else $error("divider done without final step");
  as_no_restart_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > 6'd1) |=> (cnt_q == $past(cnt_q) - 6'd1) || $past(req_i.start))
    else $error("divider count skipped");
  as_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");

endmodule
